// File: rtl/core/bds_pkg.sv
// bds_pkg: shared types and constants for the 2x2 box downsampler.
// No dependencies.
package bds_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int IDX_W        = $clog2(LINE_DEPTH);
    localparam int CNT_W        = $clog2(MAX_WIDTH);
    localparam int DIM_W        = 13;
    localparam int PIX_W        = 8;
    localparam int PAIR_W       = PIX_W + 1;
    localparam int SUM_W        = PIX_W + 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [0:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_SOURCE_HEIGHT = 1'b1;

    typedef enum logic [0:0] {
        OP_STORE = 1'b0,
        OP_BLEND = 1'b1
    } op_t;

    typedef struct packed {
        op_t                kind;
        logic [IDX_W-1:0]   idx;
        logic [PAIR_W-1:0]  pair;
        logic               last;
    } job_t;

endpackage

// File: rtl/core/bds_ram.sv
// bds_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bds_front.sv
// bds_front: size registers, raster position tracking and pair summing.
// Emits one job per odd column. Depends on bds_pkg.
module bds_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [0:0]                cfg_index,
    input  logic [bds_pkg::DIM_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bds_pkg::PIX_W-1:0] s_tdata,
    output logic                      q_push,
    output bds_pkg::job_t             q_job,
    input  logic                      q_full
);
    import bds_pkg::*;

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [PIX_W-1:0]  held_reg, held_next;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [DIM_W-1:0]  col_inc, row_inc;
    logic              accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (width_reg < DIM_W'(2))
            w_eff = DIM_W'(2);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < DIM_W'(2))
            h_eff = DIM_W'(2);
        else if (height_reg > DIM_W'(HEIGHT_LIMIT))
            h_eff = DIM_W'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    assign col_inc = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc = DIM_W'(row_reg) + DIM_W'(1);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  width_next  = cfg_data;
                REG_SOURCE_HEIGHT: height_next = cfg_data;
                default:           width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (!col_reg[0])
                held_next = s_tdata;
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        q_push     = accept && col_reg[0];
        q_job.kind = row_reg[0] ? OP_BLEND : OP_STORE;
        q_job.idx  = col_reg[CNT_W-1:1];
        q_job.pair = PAIR_W'(held_reg) + PAIR_W'(s_tdata);
        q_job.last = (DIM_W'(col_reg) == {w_eff[DIM_W-1:1], 1'b0} - DIM_W'(1))
                  && (DIM_W'(row_reg) == {h_eff[DIM_W-1:1], 1'b0} - DIM_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            held_reg   <= held_next;
        end
    end

endmodule

// File: rtl/core/bds_queue.sv
// bds_queue: small job FIFO between front and back.
// Depends on bds_pkg.
module bds_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bds_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output bds_pkg::job_t head_job,
    output logic          empty
);
    import bds_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = pop  ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/bds_back.sv
// bds_back: line store of pair sums, block sum and output register.
// Depends on bds_pkg and bds_ram.
module bds_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bds_pkg::job_t             head_job,
    input  logic                      empty,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bds_pkg::PIX_W-1:0] m_tdata,
    output logic                      m_tlast
);
    import bds_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [PAIR_W-1:0] s1_pair_reg;
    logic              s1_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_avg_reg;
    logic              out_last_reg;
    logic [PAIR_W-1:0] line_rdata;
    logic [SUM_W-1:0]  block_sum;
    logic              out_load, s1_free, do_read, do_write;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s1_free  = !s1_valid_reg || out_load;
    assign pop      = !empty && ((head_job.kind == OP_STORE) || s1_free);
    assign do_write = pop && (head_job.kind == OP_STORE);
    assign do_read  = pop && (head_job.kind == OP_BLEND);

    bds_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (do_write),
        .waddr (head_job.idx),
        .wdata (head_job.pair),
        .re    (do_read),
        .raddr (head_job.idx),
        .rdata (line_rdata)
    );

    assign block_sum = SUM_W'(line_rdata) + SUM_W'(s1_pair_reg);

    always_comb
    begin
        s1_valid_next  = do_read || (s1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            s1_pair_reg <= head_job.pair;
            s1_last_reg <= head_job.last;
        end
        if (out_load)
        begin
            out_avg_reg  <= block_sum[SUM_W-1:2];
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_avg_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/core/box_downsample_2x2_top.sv
// box_downsample_2x2_top: 2x2 box filter with decimation by two each way.
// Depends on bds_pkg, bds_front, bds_queue, bds_back (and bds_ram).
//
// Usage:
//   s_* : source grey pixels, raster order, one per accepted item.
//   m_* : one averaged pixel per 2x2 block, emitted on the second pixel of
//         each pair in odd rows; tlast marks the final block of the frame.
//   cfg_*: source width (index 0) and height (index 1); write only when idle.
// Throughput: while m_tready is high, one pixel per clock; the back end
//   retires one job per cycle, limited by the single line store port pair.
// Path to m_tvalid: the closing pixel's job is queued when it is accepted,
//   then the line store is read, then the output register is loaded.
// Reset: size 640x480, position at frame start, queue and outputs empty.
//   The line store is not cleared; each odd row reads only what the row
//   above wrote.
// Stall: the output register holds while m_tready is low; the 4-entry
//   queue absorbs the gap and s_tready drops only once it fills.
module box_downsample_2x2_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [0:0]                cfg_index,
    input  logic [bds_pkg::DIM_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bds_pkg::PIX_W-1:0] s_tdata,   // [7:0] pixel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bds_pkg::PIX_W-1:0] m_tdata,   // [7:0] average
    output logic                      m_tlast
);
    import bds_pkg::*;

    job_t push_job, head_job;
    logic push, full, pop, empty;

    bds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_push    (push),
        .q_job     (push_job),
        .q_full    (full)
    );

    bds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    bds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
